/* design/longest_step_two_run_tracker_assert.svh */
// assertion macros for the step-two run tracker
// used by longest_step_two_run_tracker.sv, expects clk and rst in scope
`ifndef LONGEST_STEP_TWO_RUN_TRACKER_ASSERT_SVH
`define LONGEST_STEP_TWO_RUN_TRACKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/ltr_pkg.sv */
// shared types and constants of the step-two run tracker
// no dependencies
package ltr_pkg;
  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;
  localparam int NVAL = 1 << VALUE_BITS;
  localparam int HALF = NVAL >> 1;
  localparam int HIST_BITS = VALUE_BITS - 1;
  localparam int HCNT_BITS = 9;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [VALUE_BITS:0] wide_t;
  typedef logic [HIST_BITS-1:0] haddr_t;
  typedef logic [HCNT_BITS-1:0] hcnt_t;
  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_QUERY = 2'd2;
  localparam count_t CMAX = {COUNT_BITS{1'b1}};
endpackage

/* design/ltr_if.sv */
// request and result channels of the step-two run tracker
// depends on ltr_pkg
interface ltr_req_if import ltr_pkg::*; ();
  logic valid;
  logic ready;
  opcode_t opcode;
  value_t value;
  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

interface ltr_rsp_if import ltr_pkg::*; ();
  logic valid;
  logic ready;
  value_t longest_run;
  modport source (output valid, longest_run, input ready);
  modport sink (input valid, longest_run, output ready);
endinterface

/* design/longest_step_two_run_tracker.sv */
// one request at a time; insert only updates the count if it was nonzero, else also joins runs
// remove of a last copy walks the present neighbors on each side, then splits the run
// query scans the histogram memory one length per cycle from the top;
// a result waits in an output register while the next request is taken
// after reset a clearing pass zeroes all memories; no request is taken meanwhile
module longest_step_two_run_tracker import ltr_pkg::*; (
  input logic clk,
  input logic rst,
  ltr_req_if.sink req,
  ltr_rsp_if.source rsp
);
  `include "longest_step_two_run_tracker_assert.svh"

  localparam logic [3:0] ST_IDLE = 4'd0, ST_CLR = 4'd1, ST_M = 4'd2, ST_J1 = 4'd3,
    ST_J2 = 4'd4, ST_J3 = 4'd5, ST_WL = 4'd6, ST_WD = 4'd7, ST_PW1 = 4'd8,
    ST_PW2 = 4'd9, ST_HR = 4'd10, ST_HW = 4'd11, ST_QS = 4'd12, ST_QO = 4'd13;

  // memories
  count_t mult_mem [NVAL];
  value_t rstart_mem [NVAL];
  value_t rend_mem [NVAL];
  logic [2*HCNT_BITS-1:0] hist_mem [HALF];

  logic [3:0] state;
  value_t clr;
  opcode_t op;
  value_t v;
  value_t left;
  value_t right;
  wide_t p;
  logic dir;
  wide_t hlen [3];
  logic hinc [3];
  logic [1:0] hi;
  value_t qlen;
  value_t qres;
  logic ov;
  value_t od;

  value_t mult_ra, mult_wa, rs_ra, rs_wa, re_ra, re_wa;
  haddr_t hist_ra, hist_wa;
  count_t mult_rd, mult_wd;
  value_t rs_rd, rs_wd, re_rd, re_wd;
  logic [2*HCNT_BITS-1:0] hist_rd, hist_wd;
  logic mult_we, rs_we, re_we, hist_we;

  value_t vm2, vp2, r_now, cnt_tot;
  wide_t n_join, cur_len;
  logic cur_skip;
  hcnt_t hc_old, hc_new;

  assign vm2 = v - value_t'(2);
  assign vp2 = v + value_t'(2);
  assign r_now = ((v <= value_t'(NVAL - 3)) && (mult_rd != '0)) ? rs_rd : '0;
  assign n_join = wide_t'(left) + wide_t'(r_now) + wide_t'(1);
  assign cnt_tot = left + right + value_t'(1);
  assign cur_len = hlen[hi];
  assign cur_skip = (cur_len == '0) || (cur_len > wide_t'(HALF));
  assign hc_old = v[0] ? hist_rd[2*HCNT_BITS-1:HCNT_BITS] : hist_rd[HCNT_BITS-1:0];
  assign hc_new = hinc[hi] ? hc_old + hcnt_t'(1)
                : ((hc_old != '0) ? hc_old - hcnt_t'(1) : hc_old);

  // memory ports
  always_ff @(posedge clk) begin
    if (mult_we) mult_mem[mult_wa] <= mult_wd;
    mult_rd <= mult_mem[mult_ra];
    if (rs_we) rstart_mem[rs_wa] <= rs_wd;
    rs_rd <= rstart_mem[rs_ra];
    if (re_we) rend_mem[re_wa] <= re_wd;
    re_rd <= rend_mem[re_ra];
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd <= hist_mem[hist_ra];
  end

  // memory addressing per state
  always_comb begin
    mult_ra = req.value;
    rs_ra = vp2;
    re_ra = vm2;
    hist_ra = haddr_t'(HALF - 1);
    mult_we = 1'b0; mult_wa = v; mult_wd = '0;
    rs_we = 1'b0; rs_wa = v; rs_wd = '0;
    re_we = 1'b0; re_wa = v; re_wd = '0;
    hist_we = 1'b0; hist_wa = haddr_t'(cur_len - wide_t'(1)); hist_wd = hist_rd;
    case (state)
      ST_CLR: begin
        mult_we = 1'b1; mult_wa = clr;
        rs_we = 1'b1; rs_wa = clr;
        re_we = 1'b1; re_wa = clr;
        hist_we = 1'b1; hist_wa = clr[HIST_BITS-1:0]; hist_wd = '0;
      end
      ST_M: begin
        if (op == OP_INSERT) begin
          mult_we = (mult_rd != CMAX);
          mult_wd = mult_rd + count_t'(1);
        end else begin
          mult_we = (mult_rd != '0);
          mult_wd = mult_rd - count_t'(1);
        end
      end
      ST_J1: mult_ra = vm2;
      ST_J2: mult_ra = vp2;
      ST_J3: begin
        rs_we = 1'b1; rs_wa = v - value_t'({left, 1'b0}); rs_wd = value_t'(n_join);
        re_we = 1'b1; re_wa = v + value_t'({r_now, 1'b0}); re_wd = value_t'(n_join);
      end
      ST_WL: mult_ra = p[VALUE_BITS-1:0];
      ST_PW1: begin
        re_we = (left != '0); re_wa = vm2; re_wd = left;
        rs_we = (left != '0); rs_wa = v - value_t'({left, 1'b0}); rs_wd = left;
      end
      ST_PW2: begin
        rs_we = (right != '0); rs_wa = vp2; rs_wd = right;
        re_we = (right != '0); re_wa = v + value_t'({right, 1'b0}); re_wd = right;
      end
      ST_HR: hist_ra = haddr_t'(cur_len - wide_t'(1));
      ST_HW: begin
        hist_we = 1'b1;
        hist_wd = v[0] ? {hc_new, hist_rd[HCNT_BITS-1:0]}
                       : {hist_rd[2*HCNT_BITS-1:HCNT_BITS], hc_new};
      end
      ST_QS: hist_ra = haddr_t'(qlen - value_t'(2));
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = ov;
  assign rsp.longest_run = od;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      clr <= '0;
      ov <= 1'b0;
      hi <= '0;
    end else begin
      // result taken; a new one loaded in ST_QO replaces it there
      if (ov && rsp.ready && state != ST_QO) ov <= 1'b0;
      case (state)
        ST_CLR: begin
          clr <= clr + value_t'(1);
          if (clr == value_t'(NVAL - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req.valid) begin
            op <= req.opcode;
            v <= req.value;
            qlen <= value_t'(HALF);
            if (req.opcode == OP_INSERT || req.opcode == OP_REMOVE) state <= ST_M;
            else state <= ST_QS;
          end
        end
        ST_M: begin
          state <= ST_IDLE;
          if (op == OP_INSERT) begin
            if (mult_rd == '0) state <= ST_J1;
          end else if (mult_rd == count_t'(1)) begin
            left <= '0;
            right <= '0;
            dir <= 1'b0;
            p <= wide_t'(v) - wide_t'(2);
            state <= ST_WL;
          end
        end
        ST_J1: state <= ST_J2;
        ST_J2: begin
          left <= ((v >= value_t'(2)) && (mult_rd != '0)) ? re_rd : '0;
          state <= ST_J3;
        end
        ST_J3: begin
          hlen[0] <= wide_t'(left); hinc[0] <= 1'b0;
          hlen[1] <= wide_t'(r_now); hinc[1] <= 1'b0;
          hlen[2] <= n_join; hinc[2] <= 1'b1;
          hi <= '0;
          state <= ST_HR;
        end
        // neighbor walk, left then right
        ST_WL: begin
          if (p[VALUE_BITS]) begin
            if (!dir) begin
              dir <= 1'b1;
              p <= wide_t'(v) + wide_t'(2);
            end else begin
              state <= ST_PW1;
            end
          end else begin
            state <= ST_WD;
          end
        end
        ST_WD: begin
          state <= ST_WL;
          if (mult_rd != '0) begin
            if (dir) begin
              right <= right + value_t'(1);
              p <= p + wide_t'(2);
            end else begin
              left <= left + value_t'(1);
              p <= p - wide_t'(2);
            end
          end else if (!dir) begin
            dir <= 1'b1;
            p <= wide_t'(v) + wide_t'(2);
          end else begin
            state <= ST_PW1;
          end
        end
        ST_PW1: begin
          hlen[0] <= wide_t'(cnt_tot); hinc[0] <= 1'b0;
          hlen[1] <= wide_t'(left); hinc[1] <= 1'b1;
          hlen[2] <= wide_t'(right); hinc[2] <= 1'b1;
          hi <= '0;
          state <= ST_PW2;
        end
        ST_PW2: state <= ST_HR;
        // histogram read-modify-write
        ST_HR: begin
          if (!cur_skip) begin
            state <= ST_HW;
          end else if (hi == 2'd2) begin
            state <= ST_IDLE;
          end else begin
            hi <= hi + 2'd1;
          end
        end
        ST_HW: begin
          if (hi == 2'd2) begin
            state <= ST_IDLE;
          end else begin
            hi <= hi + 2'd1;
            state <= ST_HR;
          end
        end
        // downward histogram scan
        ST_QS: begin
          if (hist_rd != '0) begin
            qres <= qlen;
            state <= ST_QO;
          end else if (qlen == value_t'(1)) begin
            qres <= '0;
            state <= ST_QO;
          end else begin
            qlen <= qlen - value_t'(1);
          end
        end
        ST_QO: begin
          if (!ov || rsp.ready) begin
            ov <= 1'b1;
            od <= qres;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LTR_ASSERT_NOW(a_ready_idle, req.ready, state == ST_IDLE, "ready outside idle")
  `LTR_ASSERT_NOW(a_result_range, rsp.valid, rsp.longest_run <= value_t'(HALF), "result too long")
  `LTR_ASSERT_NEXT(a_query_scan, req.valid && req.ready && req.opcode == OP_QUERY,
    state == ST_QS, "query did not start scan")
  `LTR_ASSERT_NOW(a_hist_len, state == ST_HW, !cur_skip, "histogram write with bad length")
endmodule

/* bench/longest_step_two_run_tracker_tb.sv */
// testbench for the step-two run tracker: directed table, then random requests
// in idling phases, each query checked against a behavioral predictor
// depends on ltr_pkg, ltr_if and the block longest_step_two_run_tracker
module longest_step_two_run_tracker_tb;
  import ltr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  // unused opcode, answered as a query
  localparam opcode_t OP_SPARE = 2'd3;

  typedef struct {
    opcode_t op;
    value_t val;
    bit has_exp;
    int exp_len;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 1'b0;
  int quiet_cycles = 0;

  ltr_req_if req ();
  ltr_rsp_if rsp ();

  longest_step_two_run_tracker u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int unsigned counts [NVAL];
  int run_hist [2][HALF+1];
  int exp_runs [$];

  function automatic bit present(int v);
    if (v < 0 || v >= NVAL) return 1'b0;
    return counts[v] != 0;
  endfunction

  function automatic int run_through(int v, int dir);
    int n;
    int p;
    n = 0;
    p = v + 2 * dir;
    while (present(p)) begin
      n++;
      p += 2 * dir;
    end
    return n;
  endfunction

  function automatic void hist_move(int par, int len, int delta);
    if (len == 0 || len > HALF) return;
    if (delta > 0) run_hist[par][len]++;
    else if (run_hist[par][len] != 0) run_hist[par][len]--;
  endfunction

  // update the multiset and run histogram, return the answer for a query
  function automatic int track_request(opcode_t op, value_t val);
    int v;
    int par;
    int left;
    int right;
    v = int'(val);
    par = v & 1;
    if (op == OP_INSERT) begin
      if (counts[v] == 0) begin
        left = run_through(v, -1);
        right = run_through(v, 1);
        hist_move(par, left, -1);
        hist_move(par, right, -1);
        hist_move(par, left + 1 + right, 1);
        counts[v] = 1;
      end else if (counts[v] < int'(CMAX)) begin
        counts[v]++;
      end
      return -1;
    end
    if (op == OP_REMOVE) begin
      if (counts[v] != 0) begin
        counts[v]--;
        if (counts[v] == 0) begin
          left = run_through(v, -1);
          right = run_through(v, 1);
          hist_move(par, left + 1 + right, -1);
          hist_move(par, left, 1);
          hist_move(par, right, 1);
        end
      end
      return -1;
    end
    for (int len = HALF; len >= 1; len--)
      if (run_hist[0][len] != 0 || run_hist[1][len] != 0) return len;
    return 0;
  endfunction

  // result sink with random stall
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (rsp.valid && rsp.ready) begin
        if (exp_runs.size() == 0) begin
          $error("unexpected result longest_run=%0d", rsp.longest_run);
          failed = 1'b1;
        end else begin
          int want;
          want = exp_runs.pop_front();
          if (int'(rsp.longest_run) != want) begin
            $error("longest_run: expected %0d, actual %0d", want, rsp.longest_run);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // present one request, honoring the sender idle rate; valid stays up afterwards
  task automatic send_request(opcode_t op, value_t val, bit has_exp, int exp_len);
    int want;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    want = track_request(op == OP_SPARE ? OP_QUERY : op, val);
    if (want >= 0) begin
      if (has_exp && want != exp_len) begin
        $error("longest_run: expected %0d, actual %0d (predictor)", exp_len, want);
        failed = 1'b1;
      end
      exp_runs.push_back(want);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (exp_runs.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // random traffic; clustered values so runs grow, merge and split
  task automatic random_phase(int n_items, int base, int span);
    opcode_t op;
    value_t val;
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 5) val = value_t'($urandom_range(NVAL - 1));
      else val = value_t'(base + $urandom_range(span));
      r = $urandom_range(99);
      if (r < 50) op = OP_INSERT;
      else if (r < 80) op = OP_REMOVE;
      else if (r < 97) op = OP_QUERY;
      else op = OP_SPARE;
      send_request(op, val, 1'b0, 0);
    end
  endtask

  stim_row_t directed [] = '{
    '{OP_QUERY, 10'd0, 1'b1, 0},
    '{OP_REMOVE, 10'd5, 1'b0, 0},
    '{OP_INSERT, 10'd0, 1'b0, 0},
    '{OP_QUERY, 10'd0, 1'b1, 1},
    '{OP_INSERT, 10'd1023, 1'b0, 0},
    '{OP_INSERT, 10'd4, 1'b0, 0},
    '{OP_INSERT, 10'd2, 1'b0, 0},
    '{OP_QUERY, 10'd0, 1'b1, 3},
    '{OP_INSERT, 10'd2, 1'b0, 0},
    '{OP_REMOVE, 10'd2, 1'b0, 0},
    '{OP_QUERY, 10'd0, 1'b0, 0},
    '{OP_REMOVE, 10'd2, 1'b0, 0},
    '{OP_SPARE, 10'd1023, 1'b0, 0},
    '{OP_INSERT, 10'd1021, 1'b0, 0},
    '{OP_INSERT, 10'd1019, 1'b0, 0},
    '{OP_QUERY, 10'd512, 1'b0, 0},
    '{OP_INSERT, 10'd2, 1'b0, 0},
    '{OP_REMOVE, 10'd1021, 1'b0, 0},
    '{OP_QUERY, 10'd0, 1'b0, 0},
    '{OP_REMOVE, 10'd1000, 1'b0, 0},
    '{OP_QUERY, 10'd0, 1'b0, 0}
  };

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_INSERT;
    req.value = '0;
    foreach (counts[i]) counts[i] = 0;
    foreach (run_hist[p, l]) run_hist[p][l] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (directed[i])
      send_request(directed[i].op, directed[i].val, directed[i].has_exp, directed[i].exp_len);

    // raise one count several times, then drain it partly
    repeat (6) send_request(OP_INSERT, 10'd700, 1'b0, 0);
    repeat (4) send_request(OP_REMOVE, 10'd700, 1'b0, 0);
    send_request(OP_QUERY, 10'd0, 1'b0, 0);

    // sender holds off until every result is back
    wait_drained();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(400, 0, 63);
    send_idle_pct = 84; recv_stall_pct = 0;  random_phase(300, 480, 63);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 84; random_phase(300, 960, 63);
    send_idle_pct = 14; recv_stall_pct = 14; random_phase(400, 0, 1023);
    send_idle_pct = 0;  recv_stall_pct = 0;

    wait_drained();
    if (!failed) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
